// File: hw/rtl/chip8_cpu_core_defines.svh
// Assertion macros for the chip8c RTL; chip8c_ctrl is the file that includes them.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CHIP8_CPU_CORE_DEFINES_SVH
`define CHIP8_CPU_CORE_DEFINES_SVH

// same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/chip8c_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the chip8c core.
// No dependencies.
package chip8c_pkg;

    localparam int STACK_DEPTH_DEF    = 16;
    localparam int DISPLAY_WIDTH_DEF  = 64;
    localparam int DISPLAY_HEIGHT_DEF = 32;
    localparam int MEMORY_BYTES_DEF   = 4096;
    localparam int ROW_BITS           = 64;
    localparam int FONT_BYTES         = 80;
    localparam logic [11:0] PC_RESET  = 12'd512;

    localparam logic [2:0] REQ_EXEC   = 3'd0;
    localparam logic [2:0] REQ_TICK   = 3'd1;
    localparam logic [2:0] REQ_MEM_WR = 3'd2;
    localparam logic [2:0] REQ_MEM_RD = 3'd3;
    localparam logic [2:0] REQ_ROW_RD = 3'd4;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_WAIT   = 2'd1;
    localparam logic [1:0] STAT_BAD_OP = 2'd2;
    localparam logic [1:0] STAT_STACK  = 2'd3;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_MEM_CAP, ST_ROW_CAP,
        ST_FETCH_HI, ST_FETCH_LO, ST_READ_X, ST_READ_Y, ST_SPLIT,
        ST_XMOD, ST_DRAW_RD, ST_DRAW_WR, ST_BCD, ST_STORE,
        ST_LD_RD, ST_LD_WR, ST_EXEC, ST_DONE
    } ctl_state_t;

    typedef enum logic [4:0] {
        DOP_NONE, DOP_CLEAR, DOP_LATCH, DOP_MEM_WR, DOP_MEM_RD, DOP_MEM_CAP,
        DOP_ROW_RD, DOP_ROW_CAP, DOP_TICK, DOP_FETCH_HI, DOP_FETCH_LO,
        DOP_READ_X, DOP_READ_Y, DOP_XYMOD, DOP_DRAW_RD, DOP_DRAW_WR,
        DOP_BCD, DOP_STORE, DOP_LD_RD, DOP_LD_WR, DOP_EXEC
    } dp_op_t;

    typedef enum logic [2:0] {
        CL_EXEC, CL_DRAW, CL_BCD, CL_STORE, CL_LOAD
    } instr_class_t;

    typedef struct packed {
        dp_op_t op;
        logic   resp;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0]  req;
        logic        halted;
        logic [15:0] ir;
        logic [3:0]  cnt;
        logic        clr_done;
        logic        mod_done;
    } dp_stat_t;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        b = 8'd0;
        if (idx < 7'(FONT_BYTES))
        begin
            b = FONT_ROM[idx];
        end
        return b;
    endfunction

    // class of an instruction: the multi-step sequence it needs before the final step, or CL_EXEC
    function automatic instr_class_t classify(input logic [15:0] ir);
        instr_class_t c;
        c = CL_EXEC;
        if (ir[15:12] == 4'hD)
        begin
            c = CL_DRAW;
        end
        else if (ir[15:12] == 4'hF)
        begin
            if (ir[7:0] == 8'h33)
            begin
                c = CL_BCD;
            end
            else if (ir[7:0] == 8'h55)
            begin
                c = CL_STORE;
            end
            else if (ir[7:0] == 8'h65)
            begin
                c = CL_LOAD;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/chip8c_req_if.sv
`timescale 1ns / 1ps
// Request channel of the chip8c core: valid/ready plus one request word.
// No dependencies.
interface chip8c_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] keys_down;
    logic        new_key_valid;
    logic [3:0]  new_key_code;
    logic [7:0]  random_byte;

    modport source (
        output valid, req_type, address, write_data, keys_down,
               new_key_valid, new_key_code, random_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, address, write_data, keys_down,
               new_key_valid, new_key_code, random_byte,
        output ready
    );
endinterface

// File: hw/rtl/chip8c_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the chip8c core: valid/ready plus one result word.
// No dependencies.
interface chip8c_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] program_counter;
    logic [63:0] read_data;
    logic        sound_on;
    logic        display_changed;

    modport source (
        output valid, status, program_counter, read_data, sound_on, display_changed,
        input  ready
    );
    modport sink (
        input  valid, status, program_counter, read_data, sound_on, display_changed,
        output ready
    );
endinterface

// File: hw/rtl/chip8c_dp.sv
`timescale 1ns / 1ps
// Datapath of the chip8c core: memory, registers, stack, display, ALU.
// Depends on chip8c_pkg; driven by chip8c_ctrl through dp_cmd_t.
module chip8c_dp
    import chip8c_pkg::*;
#(
    parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
    parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF,
    parameter int MEMORY_BYTES   = MEMORY_BYTES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  dp_cmd_t        cmd,
    output dp_stat_t       stat,
    input  logic [2:0]     req_type,
    input  logic [11:0]    address,
    input  logic [7:0]     write_data,
    input  logic [15:0]    keys_down,
    input  logic           new_key_valid,
    input  logic [3:0]     new_key_code,
    input  logic [7:0]     random_byte,
    output logic [1:0]     status,
    output logic [11:0]    program_counter,
    output logic [63:0]    read_data,
    output logic           sound_on,
    output logic           display_changed
);

    localparam int MAW = $clog2(MEMORY_BYTES);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int RW  = $clog2(DISPLAY_HEIGHT);

    // latched request word
    logic [2:0]  req_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [15:0] keys_reg;
    logic        nkv_reg;
    logic [3:0]  nkc_reg;
    logic [7:0]  rnd_reg;

    logic [15:0] ir_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  xm_reg;
    logic [7:0]  ym_reg;
    logic        hit_reg;

    logic [11:0]    pc_reg;
    logic [11:0]    i_reg;
    logic [SPW-1:0] sp_reg;
    logic [7:0]     dt_reg;
    logic [7:0]     st_reg;
    logic           halted_reg;
    logic [1:0]     hcode_reg;
    logic           wait_reg;
    logic           changed_reg;
    logic [63:0]    data_reg;
    logic [MAW-1:0] clr_reg;

    logic [7:0]  mem [MEMORY_BYTES];
    logic [7:0]  mem_rd_reg;
    logic [7:0]  vregs_reg [16];
    logic [11:0] stack [STACK_DEPTH];
    logic [11:0] stk_rd_reg;
    logic [ROW_BITS-1:0] rows [DISPLAY_HEIGHT];
    logic [DISPLAY_HEIGHT-1:0] row_vld_reg;
    logic [ROW_BITS-1:0] row_rd_reg;
    logic                row_ok_reg;

    logic [1:0]  o_status_reg;
    logic [11:0] o_pc_reg;
    logic [63:0] o_data_reg;
    logic        o_sound_reg;
    logic        o_changed_reg;

    function automatic logic [MAW-1:0] wrap_addr(input logic [12:0] a);
        logic [12:0] t;
        t = a;
        for (int k = 0; k < 4; k++)
        begin
            if (t >= 13'(MEMORY_BYTES))
            begin
                t = t - 13'(MEMORY_BYTES);
            end
        end
        return t[MAW-1:0];
    endfunction

    // ---------------- memory ports ----------------
    logic [12:0]    i_plus_cnt;
    logic [12:0]    rd_a;
    logic [12:0]    wr_a;
    logic           mem_we;
    logic [7:0]     mem_wd;
    logic [3:0]     v_ra;
    logic [7:0]     v_rd;
    logic [7:0]     bcd_h;
    logic [7:0]     bcd_t;
    logic [7:0]     bcd_o;
    logic [7:0]     bcd_r;

    assign i_plus_cnt = {1'b0, i_reg} + {9'd0, cnt_reg};

    always_comb
    begin
        bcd_h = (vx_reg >= 8'd200) ? 8'd2 : ((vx_reg >= 8'd100) ? 8'd1 : 8'd0);
        bcd_r = vx_reg - 8'(bcd_h * 8'd100);
        bcd_t = 8'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (bcd_r >= 8'(10 * k))
            begin
                bcd_t = 8'(k);
            end
        end
        bcd_o = bcd_r - 8'(bcd_t * 8'd10);
    end

    always_comb
    begin
        rd_a = 13'd0;
        unique case (cmd.op)
            DOP_MEM_RD:             rd_a = {1'b0, addr_reg};
            DOP_FETCH_HI:           rd_a = {1'b0, pc_reg};
            DOP_FETCH_LO:           rd_a = {1'b0, pc_reg} + 13'd1;
            DOP_DRAW_RD, DOP_LD_RD: rd_a = i_plus_cnt;
            default:                rd_a = 13'd0;
        endcase
    end

    always_comb
    begin
        v_ra = 4'd0;
        unique case (cmd.op)
            DOP_READ_X: v_ra = ir_reg[11:8];
            DOP_READ_Y: v_ra = (ir_reg[15:12] == 4'hB) ? 4'h0 : ir_reg[7:4];
            DOP_STORE:  v_ra = cnt_reg;
            default:    v_ra = 4'd0;
        endcase
    end
    assign v_rd = vregs_reg[v_ra];

    always_comb
    begin
        mem_we = 1'b0;
        wr_a   = 13'd0;
        mem_wd = 8'd0;
        unique case (cmd.op)
            DOP_CLEAR:
            begin
                mem_we = 1'b1;
                wr_a   = 13'(clr_reg);
                mem_wd = (clr_reg < MAW'(FONT_BYTES)) ? font_byte(clr_reg[6:0]) : 8'd0;
            end
            DOP_MEM_WR:
            begin
                mem_we = 1'b1;
                wr_a   = {1'b0, addr_reg};
                mem_wd = wdata_reg;
            end
            DOP_BCD:
            begin
                mem_we = 1'b1;
                wr_a   = i_plus_cnt;
                mem_wd = (cnt_reg == 4'd0) ? bcd_h : ((cnt_reg == 4'd1) ? bcd_t : bcd_o);
            end
            DOP_STORE:
            begin
                mem_we = 1'b1;
                wr_a   = i_plus_cnt;
                mem_wd = v_rd;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wrap_addr(wr_a)] <= mem_wd;
        end
        mem_rd_reg <= mem[wrap_addr(rd_a)];
    end

    // ---------------- display rows ----------------
    logic [RW-1:0]       row_ra;
    logic                row_ok_next;
    logic [ROW_BITS-1:0] row_eff;
    logic [ROW_BITS-1:0] draw_mask;
    logic [6:0]          col;

    always_comb
    begin
        row_ra      = ym_reg[RW-1:0];
        row_ok_next = 1'b1;
        if (cmd.op == DOP_ROW_RD)
        begin
            row_ra      = addr_reg[RW-1:0];
            row_ok_next = (addr_reg < 12'(DISPLAY_HEIGHT));
        end
    end

    assign row_eff = row_ok_reg ? row_rd_reg : '0;

    // sprite byte placed at columns xm..xm+7, wrapping at the display width
    always_comb
    begin
        draw_mask = '0;
        col       = 7'd0;
        for (int j = 0; j < 8; j++)
        begin
            col = 7'(xm_reg) + 7'(j);
            if (col >= 7'(DISPLAY_WIDTH))
            begin
                col = col - 7'(DISPLAY_WIDTH);
            end
            if (mem_rd_reg[7-j])
            begin
                draw_mask = draw_mask | ({{(ROW_BITS-1){1'b0}}, 1'b1} << (6'd63 - col[5:0]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DOP_DRAW_WR)
        begin
            rows[ym_reg[RW-1:0]] <= row_eff ^ draw_mask;
        end
        row_rd_reg <= rows[row_ra];
    end

    // ---------------- instruction step ----------------
    logic [11:0] pc_p2;
    logic [11:0] pc_skip;
    logic [11:0] ex_pc;
    logic        ex_halt;
    logic [1:0]  ex_code;
    logic        ex_wait;
    logic        ex_we_x;
    logic [7:0]  ex_res;
    logic        ex_we_f;
    logic [7:0]  ex_flag;
    logic        ex_cls;
    logic        ex_chg;
    logic        ex_push;
    logic        ex_pop;
    logic        ex_i_we;
    logic [11:0] ex_i;
    logic        ex_dt_we;
    logic        ex_st_we;
    logic [8:0]  sum9;
    logic        key_hit;

    assign pc_p2   = pc_reg + 12'd2;
    assign pc_skip = pc_reg + 12'd4;
    assign sum9    = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign key_hit = keys_reg[vx_reg[3:0]];

    always_comb
    begin
        ex_pc    = pc_p2;
        ex_halt  = 1'b0;
        ex_code  = STAT_OK;
        ex_wait  = 1'b0;
        ex_we_x  = 1'b0;
        ex_res   = 8'd0;
        ex_we_f  = 1'b0;
        ex_flag  = 8'd0;
        ex_cls   = 1'b0;
        ex_chg   = 1'b0;
        ex_push  = 1'b0;
        ex_pop   = 1'b0;
        ex_i_we  = 1'b0;
        ex_i     = i_reg;
        ex_dt_we = 1'b0;
        ex_st_we = 1'b0;
        unique case (ir_reg[15:12])
            4'h0:
            begin
                if (ir_reg == 16'h00E0)
                begin
                    ex_cls = 1'b1;
                    ex_chg = 1'b1;
                end
                else if (ir_reg == 16'h00EE)
                begin
                    if (sp_reg == '0)
                    begin
                        ex_halt = 1'b1;
                        ex_code = STAT_STACK;
                    end
                    else
                    begin
                        ex_pop = 1'b1;
                        ex_pc  = stk_rd_reg;
                    end
                end
            end
            4'h1: ex_pc = ir_reg[11:0];
            4'h2:
            begin
                if (sp_reg >= SPW'(STACK_DEPTH))
                begin
                    ex_halt = 1'b1;
                    ex_code = STAT_STACK;
                end
                else
                begin
                    ex_push = 1'b1;
                    ex_pc   = ir_reg[11:0];
                end
            end
            4'h3: if (vx_reg == ir_reg[7:0]) ex_pc = pc_skip;
            4'h4: if (vx_reg != ir_reg[7:0]) ex_pc = pc_skip;
            4'h5:
            begin
                if (ir_reg[3:0] != 4'h0)
                begin
                    ex_halt = 1'b1;
                    ex_code = STAT_BAD_OP;
                end
                else if (vx_reg == vy_reg)
                begin
                    ex_pc = pc_skip;
                end
            end
            4'h6:
            begin
                ex_we_x = 1'b1;
                ex_res  = ir_reg[7:0];
            end
            4'h7:
            begin
                ex_we_x = 1'b1;
                ex_res  = vx_reg + ir_reg[7:0];
            end
            4'h8:
            begin
                ex_we_x = 1'b1;
                unique case (ir_reg[3:0])
                    4'h0: ex_res = vy_reg;
                    4'h1: ex_res = vx_reg | vy_reg;
                    4'h2: ex_res = vx_reg & vy_reg;
                    4'h3: ex_res = vx_reg ^ vy_reg;
                    4'h4:
                    begin
                        ex_we_f = 1'b1;
                        ex_flag = {7'd0, sum9[8]};
                        ex_res  = sum9[7:0];
                    end
                    4'h5:
                    begin
                        ex_we_f = 1'b1;
                        ex_flag = {7'd0, vx_reg >= vy_reg};
                        ex_res  = vx_reg - vy_reg;
                    end
                    4'h6:
                    begin
                        ex_we_f = 1'b1;
                        ex_flag = {7'd0, vx_reg[0]};
                        ex_res  = {1'b0, vx_reg[7:1]};
                    end
                    4'h7:
                    begin
                        ex_we_f = 1'b1;
                        ex_flag = {7'd0, vy_reg > vx_reg};
                        ex_res  = vy_reg - vx_reg;
                    end
                    4'hE:
                    begin
                        ex_we_f = 1'b1;
                        ex_flag = {7'd0, vx_reg[7]};
                        ex_res  = {vx_reg[6:0], 1'b0};
                    end
                    default:
                    begin
                        ex_we_x = 1'b0;
                        ex_halt = 1'b1;
                        ex_code = STAT_BAD_OP;
                    end
                endcase
            end
            4'h9:
            begin
                if (ir_reg[3:0] != 4'h0)
                begin
                    ex_halt = 1'b1;
                    ex_code = STAT_BAD_OP;
                end
                else if (vx_reg != vy_reg)
                begin
                    ex_pc = pc_skip;
                end
            end
            4'hA:
            begin
                ex_i_we = 1'b1;
                ex_i    = ir_reg[11:0];
            end
            4'hB: ex_pc = ir_reg[11:0] + {4'd0, vy_reg};  // vy_reg holds V0 here
            4'hC:
            begin
                ex_we_x = 1'b1;
                ex_res  = ir_reg[7:0] & rnd_reg;
            end
            4'hD:
            begin
                ex_we_f = 1'b1;
                ex_flag = {7'd0, hit_reg};
                ex_chg  = 1'b1;
            end
            4'hE:
            begin
                if (ir_reg[7:0] == 8'h9E)
                begin
                    if (key_hit) ex_pc = pc_skip;
                end
                else if (ir_reg[7:0] == 8'hA1)
                begin
                    if (!key_hit) ex_pc = pc_skip;
                end
                else
                begin
                    ex_halt = 1'b1;
                    ex_code = STAT_BAD_OP;
                end
            end
            4'hF:
            begin
                unique case (ir_reg[7:0])
                    8'h07:
                    begin
                        ex_we_x = 1'b1;
                        ex_res  = dt_reg;
                    end
                    8'h0A:
                    begin
                        if (!nkv_reg)
                        begin
                            ex_wait = 1'b1;
                            ex_pc   = pc_reg;
                        end
                        else
                        begin
                            ex_we_x = 1'b1;
                            ex_res  = {4'd0, nkc_reg};
                        end
                    end
                    8'h15: ex_dt_we = 1'b1;
                    8'h18: ex_st_we = 1'b1;
                    8'h1E:
                    begin
                        ex_i_we = 1'b1;
                        ex_i    = i_reg + {4'd0, vx_reg};
                    end
                    8'h29:
                    begin
                        ex_i_we = 1'b1;
                        ex_i    = {6'd0, vx_reg[3:0], 2'b00} + {8'd0, vx_reg[3:0]};
                    end
                    8'h33, 8'h55, 8'h65: ex_pc = pc_p2;
                    default:
                    begin
                        ex_halt = 1'b1;
                        ex_code = STAT_BAD_OP;
                    end
                endcase
            end
            default: ex_pc = pc_p2;
        endcase
        if (ex_halt)
        begin
            ex_pc = pc_reg;
        end
    end

    // ---------------- register file ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                vregs_reg[i] <= 8'd0;
            end
        end
        else
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (cmd.op == DOP_LD_WR && cnt_reg == 4'(i))
                begin
                    vregs_reg[i] <= mem_rd_reg;
                end
                else if (cmd.op == DOP_EXEC && ex_we_x && ir_reg[11:8] == 4'(i))
                begin
                    vregs_reg[i] <= ex_res;
                end
                else if (cmd.op == DOP_EXEC && ex_we_f && i == 15)
                begin
                    vregs_reg[i] <= ex_flag;
                end
            end
        end
    end

    // ---------------- return stack ----------------
    logic [SPW-1:0] sp_m1;
    assign sp_m1 = sp_reg - SPW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.op == DOP_EXEC && ex_push)
        begin
            stack[sp_reg[SIW-1:0]] <= pc_p2;
        end
        stk_rd_reg <= stack[sp_m1[SIW-1:0]];
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.op == DOP_LATCH)
        begin
            req_reg   <= req_type;
            addr_reg  <= address;
            wdata_reg <= write_data;
            keys_reg  <= keys_down;
            nkv_reg   <= new_key_valid;
            nkc_reg   <= new_key_code;
            rnd_reg   <= random_byte;
        end
        if (cmd.op == DOP_FETCH_LO)
        begin
            ir_reg[15:8] <= mem_rd_reg;
        end
        if (cmd.op == DOP_READ_X)
        begin
            ir_reg[7:0] <= mem_rd_reg;
            vx_reg      <= v_rd;
        end
        if (cmd.op == DOP_READ_Y)
        begin
            vy_reg <= v_rd;
            xm_reg <= vx_reg;
            ym_reg <= v_rd;
        end
        else if (cmd.op == DOP_XYMOD)
        begin
            if (xm_reg >= 8'(DISPLAY_WIDTH))
            begin
                xm_reg <= xm_reg - 8'(DISPLAY_WIDTH);
            end
            if (ym_reg >= 8'(DISPLAY_HEIGHT))
            begin
                ym_reg <= ym_reg - 8'(DISPLAY_HEIGHT);
            end
        end
        else if (cmd.op == DOP_DRAW_WR)
        begin
            ym_reg <= (ym_reg + 8'd1 == 8'(DISPLAY_HEIGHT)) ? 8'd0 : ym_reg + 8'd1;
        end
        if (cmd.resp)
        begin
            o_status_reg  <= halted_reg ? hcode_reg : (wait_reg ? STAT_WAIT : STAT_OK);
            o_pc_reg      <= pc_reg;
            o_data_reg    <= data_reg;
            o_sound_reg   <= (st_reg != 8'd0);
            o_changed_reg <= changed_reg;
        end
    end

    // ---------------- architectural control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 4'd0;
            hit_reg     <= 1'b0;
            pc_reg      <= PC_RESET;
            i_reg       <= 12'd0;
            sp_reg      <= '0;
            dt_reg      <= 8'd0;
            st_reg      <= 8'd0;
            halted_reg  <= 1'b0;
            hcode_reg   <= STAT_OK;
            wait_reg    <= 1'b0;
            changed_reg <= 1'b0;
            data_reg    <= 64'd0;
            clr_reg     <= '0;
            row_vld_reg <= '0;
            row_ok_reg  <= 1'b0;
        end
        else
        begin
            row_ok_reg <= row_ok_next && row_vld_reg[row_ra];
            unique case (cmd.op)
                DOP_CLEAR: clr_reg <= clr_reg + MAW'(1);
                DOP_LATCH:
                begin
                    wait_reg    <= 1'b0;
                    changed_reg <= 1'b0;
                    data_reg    <= 64'd0;
                end
                DOP_MEM_CAP: data_reg <= {56'd0, mem_rd_reg};
                DOP_ROW_CAP: data_reg <= row_eff;
                DOP_TICK:
                begin
                    if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                    if (st_reg != 8'd0) st_reg <= st_reg - 8'd1;
                end
                DOP_READ_Y:
                begin
                    cnt_reg <= 4'd0;
                    hit_reg <= 1'b0;
                end
                DOP_DRAW_WR:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    hit_reg <= hit_reg | (|(row_eff & draw_mask));
                    row_vld_reg[ym_reg[RW-1:0]] <= 1'b1;
                end
                DOP_BCD, DOP_STORE, DOP_LD_WR: cnt_reg <= cnt_reg + 4'd1;
                DOP_EXEC:
                begin
                    pc_reg      <= ex_pc;
                    wait_reg    <= ex_wait;
                    changed_reg <= ex_chg;
                    if (ex_halt)
                    begin
                        halted_reg <= 1'b1;
                        hcode_reg  <= ex_code;
                    end
                    if (ex_i_we)  i_reg  <= ex_i;
                    if (ex_dt_we) dt_reg <= vx_reg;
                    if (ex_st_we) st_reg <= vx_reg;
                    if (ex_push)  sp_reg <= sp_reg + SPW'(1);
                    if (ex_pop)   sp_reg <= sp_m1;
                    if (ex_cls)   row_vld_reg <= '0;
                end
                default:
                begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

    assign stat.req      = req_reg;
    assign stat.halted   = halted_reg;
    assign stat.ir       = ir_reg;
    assign stat.cnt      = cnt_reg;
    assign stat.clr_done = (clr_reg == MAW'(MEMORY_BYTES - 1));
    assign stat.mod_done = (xm_reg < 8'(DISPLAY_WIDTH)) && (ym_reg < 8'(DISPLAY_HEIGHT));

    assign status          = o_status_reg;
    assign program_counter = o_pc_reg;
    assign read_data       = o_data_reg;
    assign sound_on        = o_sound_reg;
    assign display_changed = o_changed_reg;

endmodule

// File: hw/rtl/chip8c_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the chip8c core: steps the datapath through each request word.
// Depends on chip8c_pkg and chip8_cpu_core_defines.svh.
`include "chip8_cpu_core_defines.svh"
module chip8c_ctrl
    import chip8c_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = DOP_NONE;
        cmd.resp       = 1'b0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = DOP_CLEAR;
                if (stat.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DOP_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.req)
                    REQ_EXEC:   state_next = stat.halted ? ST_DONE : ST_FETCH_HI;
                    REQ_TICK:
                    begin
                        cmd.op     = DOP_TICK;
                        state_next = ST_DONE;
                    end
                    REQ_MEM_WR:
                    begin
                        cmd.op     = DOP_MEM_WR;
                        state_next = ST_DONE;
                    end
                    REQ_MEM_RD:
                    begin
                        cmd.op     = DOP_MEM_RD;
                        state_next = ST_MEM_CAP;
                    end
                    REQ_ROW_RD:
                    begin
                        cmd.op     = DOP_ROW_RD;
                        state_next = ST_ROW_CAP;
                    end
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_MEM_CAP:
            begin
                cmd.op     = DOP_MEM_CAP;
                state_next = ST_DONE;
            end
            ST_ROW_CAP:
            begin
                cmd.op     = DOP_ROW_CAP;
                state_next = ST_DONE;
            end
            ST_FETCH_HI:
            begin
                cmd.op     = DOP_FETCH_HI;
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO:
            begin
                cmd.op     = DOP_FETCH_LO;
                state_next = ST_READ_X;
            end
            ST_READ_X:
            begin
                cmd.op     = DOP_READ_X;
                state_next = ST_READ_Y;
            end
            ST_READ_Y:
            begin
                cmd.op     = DOP_READ_Y;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                unique case (classify(stat.ir))
                    CL_DRAW:  state_next = ST_XMOD;
                    CL_BCD:   state_next = ST_BCD;
                    CL_STORE: state_next = ST_STORE;
                    CL_LOAD:  state_next = ST_LD_RD;
                    default:  state_next = ST_EXEC;
                endcase
            end
            ST_XMOD:
            begin
                cmd.op = DOP_XYMOD;
                if (stat.mod_done)
                begin
                    state_next = (stat.ir[3:0] == 4'h0) ? ST_EXEC : ST_DRAW_RD;
                end
            end
            ST_DRAW_RD:
            begin
                cmd.op     = DOP_DRAW_RD;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                cmd.op     = DOP_DRAW_WR;
                state_next = (stat.cnt == stat.ir[3:0] - 4'd1) ? ST_EXEC : ST_DRAW_RD;
            end
            ST_BCD:
            begin
                cmd.op = DOP_BCD;
                if (stat.cnt == 4'd2) state_next = ST_EXEC;
            end
            ST_STORE:
            begin
                cmd.op = DOP_STORE;
                if (stat.cnt == stat.ir[11:8]) state_next = ST_EXEC;
            end
            ST_LD_RD:
            begin
                cmd.op     = DOP_LD_RD;
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                cmd.op     = DOP_LD_WR;
                state_next = (stat.cnt == stat.ir[11:8]) ? ST_EXEC : ST_LD_RD;
            end
            ST_EXEC:
            begin
                cmd.op     = DOP_EXEC;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // result register free, or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.resp       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

    `CHK_IMPL(a_resp_slot, cmd.resp, (!out_valid_reg || out_ready), "result over pending word")
    `CHK_NEXT(a_resp_shown, cmd.resp, out_valid_reg, "loaded result not presented")
    `CHK_NEXT(a_accept_go, (in_valid && in_ready), (state_reg == ST_DISPATCH), "word not dispatched")
    `CHK_IMPL(a_draw_rows, (state_reg == ST_DRAW_WR), (stat.cnt != 4'hF), "sprite row overrun")

endmodule

// File: hw/rtl/chip8_cpu_core.sv
// chip8_cpu_core: CHIP-8 interpreter, one request word in, one result word out.
// Execute fetches both instruction bytes and reads Vx and Vy, then any extra steps: draw
// repeats a wrap step on Vx and Vy in parallel until both fit the display, then reads and
// writes one row per sprite line; BCD writes three digits; Fx55 stores, Fx65 loads V0..Vx.
// One word in flight; the result register frees the input. Reset: asynchronous; then a
// pass over memory loads the font and zeroes memory before the first word is taken.
`timescale 1ns / 1ps
module chip8_cpu_core
    import chip8c_pkg::*;
#(
    parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
    parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF,
    parameter int MEMORY_BYTES   = MEMORY_BYTES_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    chip8c_req_if.sink   req,
    chip8c_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    chip8c_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    chip8c_dp #(
        .STACK_DEPTH    (STACK_DEPTH),
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .MEMORY_BYTES   (MEMORY_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req.req_type),
        .address         (req.address),
        .write_data      (req.write_data),
        .keys_down       (req.keys_down),
        .new_key_valid   (req.new_key_valid),
        .new_key_code    (req.new_key_code),
        .random_byte     (req.random_byte),
        .status          (rsp.status),
        .program_counter (rsp.program_counter),
        .read_data       (rsp.read_data),
        .sound_on        (rsp.sound_on),
        .display_changed (rsp.display_changed)
    );

endmodule
